FILE: hdl/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned KindWidth = 3;

  localparam logic [KindWidth-1:0] ERR_NONE      = 3'd0;
  localparam logic [KindWidth-1:0] ERR_BAD_LEAD  = 3'd1;
  localparam logic [KindWidth-1:0] ERR_BAD_CONT  = 3'd2;
  localparam logic [KindWidth-1:0] ERR_TRUNCATED = 3'd3;
  localparam logic [KindWidth-1:0] ERR_OVERLONG  = 3'd4;
  localparam logic [KindWidth-1:0] ERR_ABOVE_MAX = 3'd5;

  localparam logic [7:0] ASCII_END   = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD_BEYOND = 8'hF8;
  localparam logic [7:0] MASK2       = 8'h1F;
  localparam logic [7:0] MASK34      = 8'h0F;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  localparam logic [CpWidth-1:0] MIN3   = 21'h000800;
  localparam logic [CpWidth-1:0] MIN4   = 21'h010000;
  localparam logic [CpWidth-1:0] CP_MAX = 21'h10FFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } utf8d_item_t;

  typedef struct packed {
    logic [CpWidth-1:0]   code_point;
    logic [KindWidth-1:0] error_kind;
  } utf8d_result_t;

  typedef struct packed {
    logic          valid;
    utf8d_result_t result;
  } utf8d_res_bus_t;

endpackage

FILE: hdl/utf8d_in_stage.sv
module utf8d_in_stage
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  utf8d_item_t in_item,
  input  logic        advance,
  output logic        in_stall,
  output logic        item_valid,
  output utf8d_item_t item
);

  logic        valid_r, valid_nxt;
  utf8d_item_t item_r;
  logic        take;

  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hdl/utf8d_step.sv
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_mode,
  input  logic           advance,
  input  utf8d_item_t    item,
  output utf8d_res_bus_t res
);

  logic [CpWidth-1:0] partial_r, partial_nxt;
  logic [1:0]         pending_r, pending_nxt;
  logic [7:0]         lead_r, lead_nxt;

  logic [7:0]           b;
  logic [CpWidth-1:0]   shifted;
  logic [1:0]           pend_dec;
  logic                 emit;
  logic [CpWidth-1:0]   cp;
  logic [KindWidth-1:0] kind;

  assign b        = item.text_byte;
  assign shifted  = {partial_r[CpWidth-7:0], b[5:0]};
  assign pend_dec = pending_r - 2'd1;

  always_comb begin
    partial_nxt = partial_r;
    pending_nxt = pending_r;
    lead_nxt    = lead_r;
    emit        = 1'b0;
    cp          = '0;
    kind        = ERR_NONE;
    if (byte_mode) begin
      emit        = 1'b1;
      cp          = {{(CpWidth-8){1'b0}}, b};
      partial_nxt = '0;
      pending_nxt = 2'd0;
      lead_nxt    = '0;
    end else if (pending_r == 2'd0) begin
      if (b < ASCII_END) begin
        emit = 1'b1;
        cp   = {{(CpWidth-8){1'b0}}, b};
      end else if (b < LEAD2_MIN) begin
        emit = 1'b1;
        kind = ERR_BAD_LEAD;
      end else begin
        lead_nxt = b;
        if (b < LEAD3_MIN) begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & MASK2};
          pending_nxt = 2'd1;
        end else if (b < LEAD4_MIN) begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & MASK34};
          pending_nxt = 2'd2;
        end else begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & MASK34};
          pending_nxt = 2'd3;
        end
        if (item.end_of_text) begin
          emit        = 1'b1;
          kind        = ERR_TRUNCATED;
          partial_nxt = '0;
          pending_nxt = 2'd0;
          lead_nxt    = '0;
        end
      end
    end else if (b[7:6] != CONT_TAG) begin
      emit        = 1'b1;
      kind        = ERR_BAD_CONT;
      partial_nxt = '0;
      pending_nxt = 2'd0;
      lead_nxt    = '0;
    end else if (pend_dec != 2'd0) begin
      partial_nxt = shifted;
      pending_nxt = pend_dec;
      if (item.end_of_text) begin
        emit        = 1'b1;
        kind        = ERR_TRUNCATED;
        partial_nxt = '0;
        pending_nxt = 2'd0;
        lead_nxt    = '0;
      end
    end else begin
      emit        = 1'b1;
      partial_nxt = '0;
      pending_nxt = 2'd0;
      lead_nxt    = '0;
      if ((lead_r == LEAD3_MIN && shifted < MIN3) ||
          (lead_r == LEAD4_MIN && shifted < MIN4)) begin
        kind = ERR_OVERLONG;
      end else if (lead_r >= LEAD_BEYOND || shifted > CP_MAX) begin
        kind = ERR_ABOVE_MAX;
      end else begin
        cp = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pending_r <= 2'd0;
      lead_r    <= '0;
    end else if (advance) begin
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
      lead_r    <= lead_nxt;
    end
  end

  assign res.valid             = advance && emit;
  assign res.result.code_point = cp;
  assign res.result.error_kind = kind;

endmodule

FILE: hdl/utf8d_out_stage.sv
module utf8d_out_stage
  import utf8d_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  utf8d_res_bus_t res,
  input  logic           out_stall,
  output logic           out_free,
  output logic           out_valid,
  output utf8d_result_t  out_result
);

  logic          valid_r, valid_nxt;
  utf8d_result_t result_r;

  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = out_free ? res.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      result_r <= res.result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

FILE: hdl/utf8_codepoint_decoder.sv
// UTF-8 decoder: one text byte per transaction, one code point (or error kind) per
// finished sequence, nothing while a sequence is still open. A byte goes through an
// input register, one combinational decode step against the held sequence state, and
// an output register, and a new byte is taken every cycle;
// the only throttle is out_stall, which reaches in_stall through the full input
// register. On any error the code point is 0 and the decoder is idle again.
// cfg_wr_data selects byte mode (each byte passes through as its own code point);
// write it only while no transaction is in flight.
module utf8_codepoint_decoder
  import utf8d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_end_of_text,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CpWidth-1:0]   out_code_point,
  output logic [KindWidth-1:0] out_error_kind
);

  logic           byte_mode_r;
  logic           item_valid;
  utf8d_item_t    in_item;
  utf8d_item_t    item;
  logic           out_free;
  logic           advance;
  utf8d_res_bus_t res;
  utf8d_result_t  out_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      byte_mode_r <= cfg_wr_data;
    end
  end

  assign in_item.text_byte   = in_text_byte;
  assign in_item.end_of_text = in_end_of_text;
  assign advance             = item_valid && out_free;

  utf8d_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .advance   (advance),
    .in_stall  (in_stall),
    .item_valid(item_valid),
    .item      (item)
  );

  utf8d_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_mode(byte_mode_r),
    .advance  (advance),
    .item     (item),
    .res      (res)
  );

  utf8d_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  assign out_code_point = out_result.code_point;
  assign out_error_kind = out_result.error_kind;

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_kind != ERR_NONE |-> out_code_point == '0)
    else $error("error transaction with nonzero code point");

  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_mode_r |-> out_code_point <= CP_MAX)
    else $error("code point above maximum");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  a_no_emit_without_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result produced while output register busy");

endmodule
